@@ rtl/halfwidth_kana_name_to_utf8_macros.svh @@
// Assertion macros for the halfwidth kana name decoder.
`ifndef HALFWIDTH_KANA_NAME_TO_UTF8_MACROS_SVH
`define HALFWIDTH_KANA_NAME_TO_UTF8_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, sampled on clk, off during reset.
`define HKU_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication, sampled on clk, off during reset.
`define HKU_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define HKU_ASSERT_NOW(lbl, ante, cons, msg)
`define HKU_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

@@ rtl/hku_pkg.sv @@
// Types, byte codes and the kana table shared by the name decoder.
package hku_pkg;

	localparam int SPC_W    = 5;
	localparam int PEND_MAX = 19;
	localparam int Q_DEPTH  = 2;
	localparam int Q_AW     = 1;

	// byte codes
	localparam logic [7:0] CH_NUL      = 8'h00;
	localparam logic [7:0] CH_SPACE    = 8'h20;
	localparam logic [7:0] CH_BSLASH   = 8'h5C;
	localparam logic [7:0] CH_TILDE    = 8'h7E;
	localparam logic [7:0] CH_ASCII_HI = 8'h7F;
	localparam logic [7:0] CH_KANA_LO  = 8'hA0;
	localparam logic [7:0] CH_KANA_HI  = 8'hE0;
	localparam logic [7:0] CH_VOICED   = 8'hDE;
	localparam logic [7:0] CH_SEMIV    = 8'hDF;
	localparam logic [7:0] U8_E3       = 8'hE3;
	localparam logic [7:0] U8_E2       = 8'hE2;
	localparam logic [7:0] U8_C2       = 8'hC2;
	localparam logic [7:0] U8_A5       = 8'hA5;
	localparam logic [7:0] U8_80       = 8'h80;
	localparam logic [7:0] U8_82       = 8'h82;
	localparam logic [7:0] U8_99       = 8'h99;
	localparam logic [7:0] U8_9A       = 8'h9A;
	localparam logic [7:0] U8_BE       = 8'hBE;

	// last two UTF-8 bytes of each halfwidth kana, indexed by byte - 0xA0
	localparam logic [15:0] KANA_TAIL [64] = '{
		16'h00A0, 16'h8082, 16'h808C, 16'h808D, 16'h8081, 16'h83BB, 16'h83B2, 16'h82A1,
		16'h82A3, 16'h82A5, 16'h82A7, 16'h82A9, 16'h83A3, 16'h83A5, 16'h83A7, 16'h8383,
		16'h83BC, 16'h82A2, 16'h82A4, 16'h82A6, 16'h82A8, 16'h82AA, 16'h82AB, 16'h82AD,
		16'h82AF, 16'h82B1, 16'h82B3, 16'h82B5, 16'h82B7, 16'h82B9, 16'h82BB, 16'h82BD,
		16'h82BF, 16'h8381, 16'h8384, 16'h8386, 16'h8388, 16'h838A, 16'h838B, 16'h838C,
		16'h838D, 16'h838E, 16'h838F, 16'h8392, 16'h8395, 16'h8398, 16'h839B, 16'h839E,
		16'h839F, 16'h83A0, 16'h83A1, 16'h83A2, 16'h83A4, 16'h83A6, 16'h83A8, 16'h83A9,
		16'h83AA, 16'h83AB, 16'h83AC, 16'h83AD, 16'h83AF, 16'h83B3, 16'h829B, 16'h829C
	};

	typedef struct packed {
		logic [7:0] name_byte;
		logic       last_byte;
	} name_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       byte_valid;
		logic       end_of_name;
		logic       saw_invalid;
	} utf_item_t;

	// one unit of output work: flush spaces, then n sequence bytes
	typedef struct packed {
		logic [SPC_W-1:0] spaces;
		logic [1:0]       n;
		logic [7:0]       b0;
		logic [7:0]       b1;
		logic [7:0]       b2;
		logic             b0_valid;
		logic             last;
		logic             inv;
	} hku_job_t;

	// queue status seen by the front and the back
	typedef struct packed {
		logic full;
		logic valid;
	} hku_qstat_t;

endpackage

@@ rtl/hku_front.sv @@
// Front end: takes raw title bytes, classifies them and builds output jobs.
module hku_front #(
	parameter int NAME_LEN = 20
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                name_valid,
	output logic                name_ready,
	input  hku_pkg::name_item_t name_item,
	input  hku_pkg::hku_qstat_t qstat,
	output logic                push,
	output hku_pkg::hku_job_t   job
);
	import hku_pkg::*;

	localparam int PEND_CAP_I = (NAME_LEN - 1 < 1) ? 1 :
		((NAME_LEN - 1 > PEND_MAX) ? PEND_MAX : NAME_LEN - 1);
	localparam logic [SPC_W-1:0] PEND_CAP = SPC_W'(PEND_CAP_I);

	logic [7:0]       prev_q;
	logic [SPC_W-1:0] pend_q;
	logic             text_q;
	logic             inv_q;

	logic [7:0]       c;
	logic [5:0]       kdiff;
	logic [15:0]      ktail;
	logic             prev_kana;
	logic             accept;
	logic             is_space;
	logic             is_bad;
	logic [1:0]       n;
	logic [7:0]       s0, s1, s2;
	logic [SPC_W-1:0] pend_nx;
	logic             text_nx;
	logic             inv_nx;

	assign c         = name_item.name_byte;
	// table index is the byte minus 0xA0, modulo 64
	assign kdiff     = c[5:0] - CH_KANA_LO[5:0];
	assign ktail     = KANA_TAIL[kdiff];
	assign prev_kana = (prev_q > CH_KANA_LO) && (prev_q < CH_VOICED);
	assign name_ready = !qstat.full;
	assign accept    = name_valid && name_ready;

	// classify the byte into its UTF-8 sequence
	always_comb begin
		s0 = CH_NUL;
		s1 = CH_NUL;
		s2 = CH_NUL;
		n = 2'd0;
		is_space = 1'b0;
		is_bad = 1'b0;
		if (c == CH_BSLASH) begin
			s0 = U8_C2; s1 = U8_A5; n = 2'd2;
		end else if (c == CH_TILDE) begin
			s0 = U8_E2; s1 = U8_80; s2 = U8_BE; n = 2'd3;
		end else if ((c == CH_VOICED || c == CH_SEMIV) && prev_kana) begin
			s0 = U8_E3; s1 = U8_82; s2 = (c == CH_VOICED) ? U8_99 : U8_9A; n = 2'd3;
		end else if (c > CH_KANA_LO && c < CH_KANA_HI) begin
			s0 = U8_E3; s1 = ktail[15:8]; s2 = ktail[7:0]; n = 2'd3;
		end else if (c == CH_NUL || c == CH_SPACE) begin
			is_space = 1'b1;
		end else if (c > CH_ASCII_HI) begin
			is_bad = 1'b1;
		end else begin
			s0 = c; n = 2'd1;
		end
	end

	// next values of the name state
	always_comb begin
		pend_nx = pend_q;
		text_nx = text_q;
		inv_nx = inv_q | is_bad;
		if (is_space) begin
			if (pend_q < PEND_CAP) begin
				pend_nx = pend_q + SPC_W'(1);
			end
		end else if (n != 2'd0) begin
			pend_nx = '0;
			text_nx = 1'b1;
		end
	end

	// job for the back end; a final byte with nothing to show gets a marker
	always_comb begin
		job.spaces = (n != 2'd0) ? pend_q : '0;
		job.n = n;
		job.b0 = s0;
		job.b1 = s1;
		job.b2 = s2;
		job.b0_valid = 1'b1;
		job.last = name_item.last_byte;
		job.inv = inv_nx;
		if (n == 2'd0 && name_item.last_byte) begin
			job.n = 2'd1;
			if (!text_nx && pend_nx != '0) begin
				job.b0 = CH_SPACE;
			end else begin
				job.b0 = CH_NUL;
				job.b0_valid = 1'b0;
			end
		end
	end

	assign push = accept && (n != 2'd0 || name_item.last_byte);

	// name state; cleared after the final byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '0;
			pend_q <= '0;
			text_q <= 1'b0;
			inv_q <= 1'b0;
		end else if (accept) begin
			if (name_item.last_byte) begin
				prev_q <= '0;
				pend_q <= '0;
				text_q <= 1'b0;
				inv_q <= 1'b0;
			end else begin
				prev_q <= c;
				pend_q <= pend_nx;
				text_q <= text_nx;
				inv_q <= inv_nx;
			end
		end
	end

endmodule

@@ rtl/hku_queue.sv @@
// Two-entry job queue between the front and back ends.
module hku_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  hku_pkg::hku_job_t   wr_job,
	input  logic                pop,
	output hku_pkg::hku_job_t   head,
	output hku_pkg::hku_qstat_t qstat
);
	import hku_pkg::*;

	hku_job_t        mem_q [Q_DEPTH];
	logic [Q_AW-1:0] wptr_q;
	logic [Q_AW-1:0] rptr_q;
	logic [Q_AW:0]   cnt_q;
	logic            do_push;
	logic            do_pop;

	assign qstat.full  = (cnt_q == (Q_AW+1)'(Q_DEPTH));
	assign qstat.valid = (cnt_q != '0);
	assign do_push = push && !qstat.full;
	assign do_pop  = pop && qstat.valid;
	assign head    = mem_q[rptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wptr_q] <= wr_job;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wptr_q <= wptr_q + Q_AW'(1);
			end
			if (do_pop) begin
				rptr_q <= rptr_q + Q_AW'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + (Q_AW+1)'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - (Q_AW+1)'(1);
			end
		end
	end

endmodule

@@ rtl/hku_back.sv @@
// Back end: walks each job one output byte per cycle into the output register while the receiver takes them.
module hku_back (
	input  logic                clk,
	input  logic                arst_n,
	input  hku_pkg::hku_qstat_t qstat,
	input  hku_pkg::hku_job_t   head,
	output logic                pop,
	output logic                utf_valid,
	input  logic                utf_ready,
	output hku_pkg::utf_item_t  utf_item
);
	import hku_pkg::*;

	hku_job_t         job_q;
	logic             busy_q;
	logic [SPC_W-1:0] spc_q;
	logic [1:0]       pos_q;
	logic             ovalid_q;
	utf_item_t        out_q;

	hku_job_t         cur;
	logic [SPC_W-1:0] cur_spc;
	logic [1:0]       cur_pos;
	logic             have;
	logic             adv;
	logic             in_spaces;
	logic             final_b;
	logic [7:0]       seq_b;
	utf_item_t        nxt;

	assign cur     = busy_q ? job_q : head;
	assign cur_spc = busy_q ? spc_q : head.spaces;
	assign cur_pos = busy_q ? pos_q : 2'd0;
	assign have    = busy_q || qstat.valid;
	assign adv     = !ovalid_q || utf_ready;
	assign pop     = adv && !busy_q && qstat.valid;

	// pick the next byte of the current job
	always_comb begin
		case (cur_pos)
			2'd0:    seq_b = cur.b0;
			2'd1:    seq_b = cur.b1;
			default: seq_b = cur.b2;
		endcase
		in_spaces = (cur_spc != '0);
		final_b = !in_spaces && (cur_pos == cur.n - 2'd1);
		nxt.out_byte = in_spaces ? CH_SPACE : seq_b;
		nxt.byte_valid = in_spaces || cur_pos != 2'd0 || cur.b0_valid;
		nxt.end_of_name = final_b && cur.last;
		nxt.saw_invalid = final_b && cur.last && cur.inv;
	end

	// job walk
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			spc_q <= '0;
			pos_q <= '0;
		end else if (adv && have) begin
			busy_q <= !final_b;
			spc_q <= in_spaces ? cur_spc - SPC_W'(1) : cur_spc;
			pos_q <= in_spaces ? cur_pos : cur_pos + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && have && !busy_q) begin
			job_q <= head;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (adv) begin
			ovalid_q <= have;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && have) begin
			out_q <= nxt;
		end
	end

	assign utf_valid = ovalid_q;
	assign utf_item  = out_q;

endmodule

@@ rtl/halfwidth_kana_name_to_utf8.sv @@
// Top level of the halfwidth kana title decoder.
// Raw title bytes come in on name_valid/name_ready with name_item; set
// name_item.last_byte on the final byte of the field. UTF-8 bytes leave on
// utf_valid/utf_ready with utf_item, one byte per transaction. The last
// transaction of a name has end_of_name set and carries saw_invalid.
// With the back end idle, the first output byte of an input byte passes
// through the job queue and then the output register.
// The front takes one byte per cycle while the two-entry job queue has
// room. The back emits one output byte per cycle while the receiver takes
// them, and a byte yields as many output bytes as its UTF-8 sequence (three
// for kana, up to 22 when held spaces are flushed); bytes that yield
// nothing queue no job, unless they end the name.
// Reset (arst_n low) clears the name state, empties the queue and drops
// the output register. When the receiver stalls, the output register
// holds, the back stops, the queue fills and then name_ready falls.
module halfwidth_kana_name_to_utf8 #(
	parameter int NAME_LEN = 20
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                name_valid,
	output logic                name_ready,
	input  hku_pkg::name_item_t name_item,
	output logic                utf_valid,
	input  logic                utf_ready,
	output hku_pkg::utf_item_t  utf_item
);
	import hku_pkg::*;
	`include "halfwidth_kana_name_to_utf8_macros.svh"

	hku_job_t   wr_job;
	hku_job_t   head;
	hku_qstat_t qstat;
	logic       push;
	logic       pop;

	hku_front #(
		.NAME_LEN (NAME_LEN)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.name_valid (name_valid),
		.name_ready (name_ready),
		.name_item  (name_item),
		.qstat      (qstat),
		.push       (push),
		.job        (wr_job)
	);

	hku_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_job (wr_job),
		.pop    (pop),
		.head   (head),
		.qstat  (qstat)
	);

	hku_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.qstat     (qstat),
		.head      (head),
		.pop       (pop),
		.utf_valid (utf_valid),
		.utf_ready (utf_ready),
		.utf_item  (utf_item)
	);

	// checks
	`HKU_ASSERT_NOW(a_full_blocks, qstat.full, !name_ready, "input taken with queue full")
	`HKU_ASSERT_NOW(a_job_nonempty, push, wr_job.n != 2'd0, "empty job queued")
	`HKU_ASSERT_NOW(a_marker_final, utf_valid && !utf_item.byte_valid,
		utf_item.end_of_name && utf_item.out_byte == CH_NUL, "empty marker not final")
	`HKU_ASSERT_NEXT(a_pop_shows, pop, utf_valid, "popped job shows no output")

endmodule

@@ bench/tb_halfwidth_kana_name_to_utf8.sv @@
// Self-checking testbench for the halfwidth kana title to UTF-8 decoder.
module tb_halfwidth_kana_name_to_utf8;
	timeunit 1ns;
	timeprecision 1ps;

	import hku_pkg::name_item_t;
	import hku_pkg::utf_item_t;

	localparam int NAME_LEN     = 20;
	localparam int SPACE_CAP    = (NAME_LEN - 1 < 1) ? 1 :
		((NAME_LEN - 1 > 19) ? 19 : NAME_LEN - 1);
	localparam int CYCLE_LIMIT  = 200000;
	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_CYCLES = 12;
	localparam int PHASE_ITEMS  = 18;

	// raw title byte codes
	localparam logic [7:0] RAW_NUL       = 8'h00;
	localparam logic [7:0] RAW_SPACE     = 8'h20;
	localparam logic [7:0] RAW_YEN       = 8'h5C;
	localparam logic [7:0] RAW_OVERLINE  = 8'h7E;
	localparam logic [7:0] RAW_ASCII_TOP = 8'h7F;
	localparam logic [7:0] RAW_KANA_BASE = 8'hA0;
	localparam logic [7:0] RAW_KANA_END  = 8'hE0;
	localparam logic [7:0] RAW_VOICED    = 8'hDE;
	localparam logic [7:0] RAW_SEMIVOICED = 8'hDF;

	// UTF-8 bytes produced
	localparam logic [7:0] UTF_YEN_LEAD   = 8'hC2;
	localparam logic [7:0] UTF_YEN_TAIL   = 8'hA5;
	localparam logic [7:0] UTF_OVL_LEAD   = 8'hE2;
	localparam logic [7:0] UTF_OVL_MID    = 8'h80;
	localparam logic [7:0] UTF_OVL_TAIL   = 8'hBE;
	localparam logic [7:0] UTF_KANA_LEAD  = 8'hE3;
	localparam logic [7:0] UTF_MARK_MID   = 8'h82;
	localparam logic [7:0] UTF_VOICED_END = 8'h99;
	localparam logic [7:0] UTF_SEMIV_END  = 8'h9A;

	// second and third UTF-8 byte of each halfwidth kana, by raw byte - 0xA0
	localparam logic [15:0] KANA_UTF_TAIL [64] = '{
		16'h00A0, 16'h8082, 16'h808C, 16'h808D, 16'h8081, 16'h83BB, 16'h83B2, 16'h82A1,
		16'h82A3, 16'h82A5, 16'h82A7, 16'h82A9, 16'h83A3, 16'h83A5, 16'h83A7, 16'h8383,
		16'h83BC, 16'h82A2, 16'h82A4, 16'h82A6, 16'h82A8, 16'h82AA, 16'h82AB, 16'h82AD,
		16'h82AF, 16'h82B1, 16'h82B3, 16'h82B5, 16'h82B7, 16'h82B9, 16'h82BB, 16'h82BD,
		16'h82BF, 16'h8381, 16'h8384, 16'h8386, 16'h8388, 16'h838A, 16'h838B, 16'h838C,
		16'h838D, 16'h838E, 16'h838F, 16'h8392, 16'h8395, 16'h8398, 16'h839B, 16'h839E,
		16'h839F, 16'h83A0, 16'h83A1, 16'h83A2, 16'h83A4, 16'h83A6, 16'h83A8, 16'h83A9,
		16'h83AA, 16'h83AB, 16'h83AC, 16'h83AD, 16'h83AF, 16'h83B3, 16'h829B, 16'h829C
	};

	// Tracks the decoder state per title byte and holds the UTF-8 bytes still owed.
	class utf8_name_checker;
		logic [7:0] prev_raw;
		int         held_spaces;
		bit         text_seen;
		bit         invalid_seen;
		utf_item_t  utf8_bytes_due[$];
		int         mismatches;

		function new();
			prev_raw     = RAW_NUL;
			held_spaces  = 0;
			text_seen    = 0;
			invalid_seen = 0;
			mismatches   = 0;
		endfunction

		function int pending();
			return utf8_bytes_due.size();
		endfunction

		task report_mismatch(string msg);
			mismatches++;
			$display("%0t MISMATCH: %s", $realtime, msg);
		endtask

		// Decode one accepted title byte into the UTF-8 bytes it releases.
		function void decode_title_byte(name_item_t item);
			logic [7:0]  c;
			logic [7:0]  seq [3];
			logic [15:0] tail;
			logic [7:0]  burst [$];
			bit          burst_ok [$];
			utf_item_t   r;
			int          n;
			bit          is_space;
			bit          prev_kana;

			c = item.name_byte;
			n = 0;
			is_space = 0;
			prev_kana = (prev_raw > RAW_KANA_BASE) && (prev_raw < RAW_VOICED);

			if (c == RAW_YEN) begin
				seq[0] = UTF_YEN_LEAD; seq[1] = UTF_YEN_TAIL; n = 2;
			end else if (c == RAW_OVERLINE) begin
				seq[0] = UTF_OVL_LEAD; seq[1] = UTF_OVL_MID; seq[2] = UTF_OVL_TAIL; n = 3;
			end else if ((c == RAW_VOICED || c == RAW_SEMIVOICED) && prev_kana) begin
				// combining mark after a plain kana
				seq[0] = UTF_KANA_LEAD;
				seq[1] = UTF_MARK_MID;
				seq[2] = (c == RAW_VOICED) ? UTF_VOICED_END : UTF_SEMIV_END;
				n = 3;
			end else if (c > RAW_KANA_BASE && c < RAW_KANA_END) begin
				tail = KANA_UTF_TAIL[(c - RAW_KANA_BASE) & 8'h3F];
				seq[0] = UTF_KANA_LEAD; seq[1] = tail[15:8]; seq[2] = tail[7:0]; n = 3;
			end else if (c == RAW_NUL || c == RAW_SPACE) begin
				is_space = 1;
			end else if (c > RAW_ASCII_TOP) begin
				invalid_seen = 1;
			end else begin
				seq[0] = c; n = 1;
			end

			// spaces are held until text follows them
			if (is_space) begin
				if (held_spaces < SPACE_CAP)
					held_spaces++;
			end else if (n > 0) begin
				repeat (held_spaces) begin
					burst.push_back(RAW_SPACE);
					burst_ok.push_back(1'b1);
				end
				held_spaces = 0;
				for (int i = 0; i < n; i++) begin
					burst.push_back(seq[i]);
					burst_ok.push_back(1'b1);
				end
				text_seen = 1;
			end
			prev_raw = c;

			// end of name: something must close it
			if (item.last_byte && burst.size() == 0) begin
				if (!text_seen && held_spaces > 0) begin
					burst.push_back(RAW_SPACE);
					burst_ok.push_back(1'b1);
				end else begin
					burst.push_back(RAW_NUL);
					burst_ok.push_back(1'b0);
				end
			end

			foreach (burst[i]) begin
				r.out_byte    = burst[i];
				r.byte_valid  = burst_ok[i];
				r.end_of_name = item.last_byte && (i == burst.size() - 1);
				r.saw_invalid = r.end_of_name && invalid_seen;
				utf8_bytes_due.push_back(r);
			end

			if (item.last_byte) begin
				prev_raw     = RAW_NUL;
				held_spaces  = 0;
				text_seen    = 0;
				invalid_seen = 0;
			end
		endfunction

		// Compare one accepted UTF-8 transaction with the oldest owed byte.
		task check_utf8_byte(utf_item_t got);
			utf_item_t want;
			if (utf8_bytes_due.size() == 0) begin
				report_mismatch($sformatf("unexpected byte %h valid %b end %b inv %b",
					got.out_byte, got.byte_valid, got.end_of_name, got.saw_invalid));
				return;
			end
			want = utf8_bytes_due.pop_front();
			if (got.out_byte !== want.out_byte || got.byte_valid !== want.byte_valid ||
			    got.end_of_name !== want.end_of_name ||
			    got.saw_invalid !== want.saw_invalid)
				report_mismatch($sformatf(
					"byte %h/%h valid %b/%b end %b/%b inv %b/%b (got/want)",
					got.out_byte, want.out_byte, got.byte_valid, want.byte_valid,
					got.end_of_name, want.end_of_name, got.saw_invalid, want.saw_invalid));
		endtask
	endclass

	logic       clk        = 1'b0;
	logic       arst_n     = 1'b0;
	logic       name_valid = 1'b0;
	logic       name_ready;
	name_item_t name_item  = '0;
	logic       utf_valid;
	logic       utf_ready  = 1'b0;
	utf_item_t  utf_item;

	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int phase_items    = 0;
	bit hold_off       = 1'b0;

	utf8_name_checker board = new();

	halfwidth_kana_name_to_utf8 #(
		.NAME_LEN(NAME_LEN)
	) u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.name_valid(name_valid),
		.name_ready(name_ready),
		.name_item (name_item),
		.utf_valid (utf_valid),
		.utf_ready (utf_ready),
		.utf_item  (utf_item)
	);

	always #4 clk = ~clk;

	// receiver: random stalls, plus the long hold-off
	always @(negedge clk) begin
		utf_ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
	end

	// watch both channels at the rising edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (name_valid && name_ready)
				board.decode_title_byte(name_item);
			if (utf_valid && utf_ready)
				board.check_utf8_byte(utf_item);
		end
	end

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("halfwidth_kana_name_to_utf8 test failed");
		$finish;
	end

	// Offer one title byte at the falling edge and hold it until taken.
	task automatic drive_title_byte(input name_item_t item);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			name_valid <= 1'b0;
			@(negedge clk);
		end
		name_valid <= 1'b1;
		name_item  <= item;
		do @(posedge clk); while (!name_ready);
	endtask

	task automatic send_title(input logic [7:0] bytes [$]);
		name_item_t item;
		foreach (bytes[i]) begin
			item.name_byte = bytes[i];
			item.last_byte = (i == bytes.size() - 1);
			drive_title_byte(item);
		end
		phase_items += bytes.size();
	endtask

	function automatic logic [7:0] rand_title_byte();
		int pick;
		pick = $urandom_range(99);
		if (pick < 30)
			return $urandom_range(8'hA1, 8'hDD);
		else if (pick < 40)
			return $urandom_range(1) ? RAW_VOICED : RAW_SEMIVOICED;
		else if (pick < 58)
			return $urandom_range(1) ? RAW_SPACE : RAW_NUL;
		else if (pick < 72)
			return $urandom_range(8'h01, 8'h7F);
		else if (pick < 77)
			return $urandom_range(1) ? RAW_YEN : RAW_OVERLINE;
		else if (pick < 87)
			return $urandom_range(1) ? $urandom_range(8'h80, 8'hA0) :
				$urandom_range(8'hE0, 8'hFF);
		return $urandom_range(255);
	endfunction

	// Random title: long space runs, padded names, blank names or free content.
	task automatic send_random_title();
		logic [7:0] bytes [$];
		int shape;
		shape = $urandom_range(9);
		case (shape)
			0: begin
				repeat ($urandom_range(18, 28)) bytes.push_back(RAW_SPACE);
				repeat ($urandom_range(1, 3)) bytes.push_back(rand_title_byte());
			end
			1: begin
				repeat ($urandom_range(1, 8)) bytes.push_back(rand_title_byte());
				while (bytes.size() < NAME_LEN)
					bytes.push_back($urandom_range(1) ? RAW_SPACE : RAW_NUL);
			end
			2: begin
				repeat ($urandom_range(1, 22))
					bytes.push_back($urandom_range(1) ? RAW_SPACE : RAW_NUL);
			end
			default: begin
				repeat ($urandom_range(1, NAME_LEN)) bytes.push_back(rand_title_byte());
			end
		endcase
		send_title(bytes);
	endtask

	// Long receiver hold-off so the decoder backs up into its input.
	task automatic hold_receiver();
		hold_off = 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_off = 1'b0;
	endtask

	initial begin
		int send_pct [5];
		int recv_pct [5];
		send_pct = '{0, 61, 0, 19, 0};
		recv_pct = '{0, 0, 61, 19, 0};

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: yen, overline, marks after kana, leading marks, invalid bytes,
		// NUL as space, trailing spaces, all-space name, empty name, leading spaces
		send_title({RAW_YEN, RAW_OVERLINE, 8'hA1, RAW_VOICED, RAW_SEMIVOICED, RAW_NUL,
			8'h41, 8'h80, 8'hFF, RAW_KANA_END, RAW_KANA_BASE, RAW_ASCII_TOP, 8'h01,
			RAW_SPACE});
		send_title({RAW_VOICED, 8'hDD, RAW_SEMIVOICED});
		send_title({RAW_SPACE, RAW_NUL});
		send_title({8'h80});
		send_title({RAW_SPACE, 8'h42});

		for (int p = 0; p < 5; p++) begin
			send_idle_pct  = send_pct[p];
			recv_stall_pct = recv_pct[p];
			if (p == 4)
				fork
					hold_receiver();
				join_none
			phase_items = 0;
			while (phase_items < PHASE_ITEMS)
				send_random_title();
		end

		@(negedge clk);
		name_valid <= 1'b0;

		while (board.pending() > 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (board.mismatches == 0)
			$display("halfwidth_kana_name_to_utf8 test passed");
		else
			$display("halfwidth_kana_name_to_utf8 test failed");
		$finish;
	end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/hku_pkg.sv
rtl/hku_front.sv
rtl/hku_queue.sv
rtl/hku_back.sv
rtl/halfwidth_kana_name_to_utf8.sv
bench/tb_halfwidth_kana_name_to_utf8.sv
